[rtl/core/time_priority_event_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the time and priority event queue
// Clocked on clk; the first form is disabled in reset, the second is not.
// ----------------------------------------------------------------------------
`ifndef TIME_PRIORITY_EVENT_QUEUE_ASSERT_SVH
`define TIME_PRIORITY_EVENT_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define TPEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TPEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TPEQ_ASSERT(label, prop, msg)
`define TPEQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/core/tpeq_pkg.sv]
// ----------------------------------------------------------------------------
// tpeq_pkg
// Types, constants and helpers shared by the event queue files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpeq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 48;
  localparam int PRIO_W      = 8;
  localparam int TAG_W       = 16;
  localparam int OCC_W       = 7;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_POP    = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PUT,
    S_POP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        [TIME_BITS-1:0] ev_time;
    logic signed [PRIO_W-1:0]    prio;
    logic        [TAG_W-1:0]     tag;
  } entry_t;

  // slot address of a ring offset; the sum stays below twice the depth
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(QUEUE_DEPTH)) ? s - SUM_W'(QUEUE_DEPTH) : s;
    return t[ADDR_W-1:0];
  endfunction

  // stored entry keeps its place ahead of a new event
  function automatic logic stays_ahead(input entry_t slot, input entry_t ev);
    logic res;
    if (slot.ev_time != ev.ev_time) begin
      res = slot.ev_time < ev.ev_time;
    end else begin
      res = $signed(slot.prio) <= $signed(ev.prio);
    end
    return res;
  endfunction

endpackage

[rtl/core/tpeq_req_if.sv]
// ----------------------------------------------------------------------------
// tpeq_req_if
// Request channel: insert or pop items with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpeq_req_if import tpeq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [TIME_BITS-1:0]     event_time;
  logic signed [PRIO_W-1:0] event_priority;
  logic [TAG_W-1:0]         event_tag;

  modport source (output valid, mode, event_time, event_priority, event_tag,
                  input ready);
  modport sink   (input valid, mode, event_time, event_priority, event_tag,
                  output ready);
endinterface

[rtl/core/tpeq_rsp_if.sv]
// ----------------------------------------------------------------------------
// tpeq_rsp_if
// Result channel: one item per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpeq_rsp_if import tpeq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [TIME_BITS-1:0]     out_time;
  logic signed [PRIO_W-1:0] out_priority;
  logic [TAG_W-1:0]         out_tag;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_time, out_priority, out_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, out_time, out_priority, out_tag, occupancy,
                  output ready);
endinterface

[rtl/core/tpeq_ram.sv]
// ----------------------------------------------------------------------------
// tpeq_ram
// Event slot store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpeq_ram import tpeq_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/time_priority_event_queue.sv]
// ----------------------------------------------------------------------------
// time_priority_event_queue
// Stable time/priority ordered event queue for a logic simulator scheduler.
//
// req carries insert (mode 0) and pop (mode 1) items; rsp returns exactly one
// result item per request: status, popped event (zero unless a pop
// succeeded) and the occupancy after the item.
// Events sit in a ring buffer held in one RAM, front at head. An insert walks
// back from the tail through a single key comparator: each cycle compares one
// stored entry and, if the new event goes ahead of it, moves it up one slot
// while the next one is read. The walk stops on the first stored entry that
// stays ahead of the new event, or at the front; an empty queue skips it. A
// full or empty refusal and a pop do no walk. req.ready is high only when the
// sequencer is idle.
// The result sits in an output register: the next item is accepted while it
// waits, and that item's result holds in the sequencer until rsp takes it.
// Reset (rst, synchronous) empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_priority_event_queue import tpeq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tpeq_req_if.sink    req,
  tpeq_rsp_if.source  rsp
);

`include "time_priority_event_queue_assert.svh"

  // sequencer state
  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] head;            // ring slot of the front event
  logic [CNT_W-1:0]  count;           // stored events
  logic [CNT_W-1:0]  pos;             // candidate ring offset for the new event
  logic [CNT_W-1:0]  pos_next;
  entry_t            new_ent;         // event being inserted
  status_t           res_status;      // pending result
  entry_t            res_ent;

  // output register
  logic              out_valid;
  status_t           out_status;
  entry_t            out_ent;
  logic [OCC_W-1:0]  out_occ;

  // RAM side
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              accept;
  logic              is_pop;
  logic              ahead;           // shared comparator output
  logic              out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_pop    = (mode_t'(req.mode) == MODE_POP);
  assign ahead     = stays_ahead(rd_data, new_ent);
  assign out_free  = !out_valid || rsp.ready;

  tpeq_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_pop) begin
            state_next = (count == '0) ? S_FIN : S_POP;
          end else if (count == CNT_W'(QUEUE_DEPTH)) begin
            state_next = S_FIN;
          end else if (count == '0) begin
            state_next = S_PUT;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        // keep walking while the new event passes entries and slots remain
        state_next = (!ahead && pos != CNT_W'(1)) ? S_CMP : S_PUT;
      end
      S_PUT:   state_next = S_FIN;
      S_POP:   state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pos_next = pos;
    rd_en    = 1'b0;
    rd_addr  = wrap_addr(SUM_W'(head) + SUM_W'(pos_next) - SUM_W'(1));
    wr_en    = 1'b0;
    wr_addr  = wrap_addr(SUM_W'(head) + SUM_W'(pos));
    wr_data  = new_ent;
    unique case (state)
      S_IDLE: begin
        if (accept && is_pop) begin
          rd_en   = (count != '0);
          rd_addr = head;
        end else if (accept) begin
          pos_next = count;
          rd_en    = (state_next == S_CMP);
          rd_addr  = wrap_addr(SUM_W'(head) + SUM_W'(count) - SUM_W'(1));
        end
      end
      S_CMP: begin
        if (!ahead) begin
          // move the compared entry one slot toward the tail
          wr_en    = 1'b1;
          wr_data  = rd_data;
          pos_next = pos - CNT_W'(1);
          rd_en    = (state_next == S_CMP);
          rd_addr  = wrap_addr(SUM_W'(head) + SUM_W'(pos) - SUM_W'(2));
        end
      end
      S_PUT: begin
        wr_en = 1'b1;
      end
      S_POP, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (state == S_POP) begin
        head  <= wrap_addr(SUM_W'(head) + SUM_W'(1));
        count <= count - CNT_W'(1);
      end else if (state == S_PUT) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      new_ent.ev_time <= req.event_time;
      new_ent.prio    <= req.event_priority;
      new_ent.tag     <= req.event_tag;
      res_ent         <= '0;
      if (is_pop) begin
        res_status <= (count == '0) ? ST_EMPTY : ST_DONE;
      end else begin
        res_status <= (count == CNT_W'(QUEUE_DEPTH)) ? ST_FULL : ST_DONE;
      end
    end
    if (state == S_POP) begin
      res_ent <= rd_data;
    end
    if (state == S_FIN && out_free) begin
      out_status <= res_status;
      out_ent    <= res_ent;
      out_occ    <= OCC_W'(count);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_time     = out_ent.ev_time;
  assign rsp.out_priority = out_ent.prio;
  assign rsp.out_tag      = out_ent.tag;
  assign rsp.occupancy    = out_occ;

  // checks
  `TPEQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `TPEQ_ASSERT(a_cmp_pos, state == S_CMP |-> pos != '0, "compare walk past front")
  `TPEQ_ASSERT(a_busy_after_accept, accept |=> !req.ready, "accepted while busy")
  `TPEQ_ASSERT(a_full_occ, out_valid && out_status == ST_FULL |-> out_occ == OCC_W'(QUEUE_DEPTH), "full refusal with room left")
  `TPEQ_ASSERT(a_empty_occ, out_valid && out_status == ST_EMPTY |-> out_occ == '0, "empty status with events stored")
  `TPEQ_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && !out_valid, "reset did not idle")

endmodule
